// ===== hw/rtl/gdfs_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gdfs_pkg
// Shared types and codes for the depth-first graph order engine.
// -----------------------------------------------------------------------------
package gdfs_pkg;

	// field widths of the stream items
	localparam int VERT_W   = 3;
	localparam int STATUS_W = 2;

	// request kinds carried in s_axis_tuser
	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_WALK = 1'b1;

	// result status codes carried in m_axis_tuser
	localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_VISIT = 2'd2;

	// one result transaction
	typedef struct packed {
		logic [VERT_W-1:0]   vertex;
		logic [STATUS_W-1:0] status;
		logic                last;
	} result_t;

endpackage

// ===== hw/rtl/gdfs_ram.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gdfs_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// -----------------------------------------------------------------------------
module gdfs_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/gdfs_out_stage.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gdfs_out_stage
// Result output register; frees the sequencer from the downstream handshake.
// -----------------------------------------------------------------------------
module gdfs_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  gdfs_pkg::result_t res,
	output logic              free,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,   // [2:0] vertex
	output logic [1:0]        m_axis_tuser,   // [1:0] status
	output logic              m_axis_tlast
);

	logic              vld_q;
	gdfs_pkg::result_t res_q;

	// slot is free when empty or drained this cycle
	assign free = !vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = {5'd0, res_q.vertex};
	assign m_axis_tuser  = res_q.status;
	assign m_axis_tlast  = res_q.last;

endmodule

// ===== hw/rtl/graph_dfs_order_engine_top.sv =====
`timescale 1ns / 1ps
// Add: each scanned list entry passes S_ADD_RD then S_ADD_CMP; a new edge answers once
// the whole list is scanned, a duplicate answers at the matching entry.
// Traversal: each stored edge of a reached vertex passes S_WALK and S_NBR, each stack pop S_WALK and S_POP;
// first visit is reported when the second is found, the last one at the walk's end.
// Throughput: one request at a time; input is ready the cycle after the final result loads.
// Reset (arst_n, async): clears control state, neighbor counts and visited marks.
// -----------------------------------------------------------------------------
// graph_dfs_order_engine_top
// Directed graph in adjacency-list RAM with a stack-based depth-first walk.
// -----------------------------------------------------------------------------
module graph_dfs_order_engine_top #(
	parameter int VERTICES = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [2:0] src_vertex, [5:3] dst_vertex
	input  logic       s_axis_tuser,   // [0] req_type
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [2:0] vertex
	output logic [1:0] m_axis_tuser,   // [1:0] status
	output logic       m_axis_tlast
);

	// only vertices reachable through the 3-bit fields hold edges
	localparam int NV    = (VERTICES < 8) ? VERTICES : 8;
	localparam int VI_W  = $clog2(NV);
	localparam int CNT_W = $clog2(NV + 1);
	localparam int NA_W  = 2 * VI_W;
	localparam int FR_W  = VI_W + CNT_W;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_ADD_RD  = 3'd1;
	localparam logic [2:0] S_ADD_CMP = 3'd2;
	localparam logic [2:0] S_WALK    = 3'd3;
	localparam logic [2:0] S_NBR     = 3'd4;
	localparam logic [2:0] S_POP     = 3'd5;

	// input decode
	logic [2:0]      src_in, dst_in;
	logic            src_ok, dst_ok;
	assign src_in = s_axis_tdata[2:0];
	assign dst_in = s_axis_tdata[5:3];
	assign src_ok = (7'(src_in) < 7'(NV));
	assign dst_ok = (7'(dst_in) < 7'(NV));

	// sequencer state
	logic [2:0]       state_q, state_d;
	logic [VI_W-1:0]  s_q, s_d, d_q, d_d;
	logic [CNT_W-1:0] scan_q, scan_d;
	logic [VI_W-1:0]  top_v_q, top_v_d;
	logic [CNT_W-1:0] top_pos_q, top_pos_d;
	logic [CNT_W-1:0] depth_q, depth_d;
	logic [VI_W-1:0]  pend_q, pend_d;
	logic [NV-1:0]    visited_q, visited_d;
	logic [CNT_W-1:0] cnt_q [NV];
	logic [CNT_W-1:0] cnt_d [NV];

	// memory ports
	logic             nbr_we, nbr_re;
	logic [NA_W-1:0]  nbr_waddr, nbr_raddr;
	logic [VI_W-1:0]  nbr_wdata, nbr_rdata;
	logic             stk_we, stk_re;
	logic [VI_W-1:0]  stk_waddr, stk_raddr;
	logic [FR_W-1:0]  stk_wdata, stk_rdata;

	// result path
	logic              res_load, out_free;
	gdfs_pkg::result_t res;

	logic [CNT_W-1:0] cnt_s, cnt_top, depth_m1, depth_m2;
	assign cnt_s    = cnt_q[s_q];
	assign cnt_top  = cnt_q[top_v_q];
	assign depth_m1 = depth_q - CNT_W'(1);
	assign depth_m2 = depth_q - CNT_W'(2);

	assign s_axis_tready = (state_q == S_IDLE);

	// next-state and memory control
	always_comb begin
		state_d   = state_q;
		s_d       = s_q;
		d_d       = d_q;
		scan_d    = scan_q;
		top_v_d   = top_v_q;
		top_pos_d = top_pos_q;
		depth_d   = depth_q;
		pend_d    = pend_q;
		visited_d = visited_q;
		cnt_d     = cnt_q;
		nbr_we    = 1'b0;
		nbr_waddr = '0;
		nbr_wdata = '0;
		nbr_re    = 1'b0;
		nbr_raddr = '0;
		stk_we    = 1'b0;
		stk_waddr = '0;
		stk_wdata = '0;
		stk_re    = 1'b0;
		stk_raddr = '0;
		res_load  = 1'b0;
		res       = '0;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					s_d = src_in[VI_W-1:0];
					d_d = dst_in[VI_W-1:0];
					if (s_axis_tuser == gdfs_pkg::REQ_ADD) begin
						if (src_ok && dst_ok) begin
							scan_d  = '0;
							state_d = S_ADD_RD;
						end
					end else if (src_ok) begin
						visited_d                    = '0;
						visited_d[src_in[VI_W-1:0]] = 1'b1;
						pend_d    = src_in[VI_W-1:0];
						top_v_d   = src_in[VI_W-1:0];
						top_pos_d = '0;
						depth_d   = CNT_W'(1);
						state_d   = S_WALK;
					end
				end
			end
			// duplicate scan: read one list entry per visit
			S_ADD_RD: begin
				if (scan_q < cnt_s) begin
					nbr_re    = 1'b1;
					nbr_raddr = {s_q, scan_q[VI_W-1:0]};
					state_d   = S_ADD_CMP;
				end else if (out_free) begin
					res_load   = 1'b1;
					res.vertex = '0;
					res.status = gdfs_pkg::ST_ADDED;
					res.last   = 1'b1;
					if (cnt_s < CNT_W'(NV)) begin
						nbr_we     = 1'b1;
						nbr_waddr  = {s_q, cnt_s[VI_W-1:0]};
						nbr_wdata  = d_q;
						cnt_d[s_q] = cnt_s + CNT_W'(1);
					end
					state_d = S_IDLE;
				end
			end
			S_ADD_CMP: begin
				if (nbr_rdata == d_q) begin
					if (out_free) begin
						res_load   = 1'b1;
						res.vertex = '0;
						res.status = gdfs_pkg::ST_DUP;
						res.last   = 1'b1;
						state_d    = S_IDLE;
					end
				end else begin
					scan_d  = scan_q + CNT_W'(1);
					state_d = S_ADD_RD;
				end
			end
			// top frame: fetch next neighbor, or pop
			S_WALK: begin
				if (top_pos_q < cnt_top) begin
					nbr_re    = 1'b1;
					nbr_raddr = {top_v_q, top_pos_q[VI_W-1:0]};
					top_pos_d = top_pos_q + CNT_W'(1);
					state_d   = S_NBR;
				end else if (depth_q == CNT_W'(1)) begin
					if (out_free) begin
						res_load   = 1'b1;
						res.vertex = 3'(pend_q);
						res.status = gdfs_pkg::ST_VISIT;
						res.last   = 1'b1;
						depth_d    = '0;
						state_d    = S_IDLE;
					end
				end else begin
					stk_re    = 1'b1;
					stk_raddr = depth_m2[VI_W-1:0];
					depth_d   = depth_m1;
					state_d   = S_POP;
				end
			end
			// fetched neighbor: skip if visited, else report previous visit, push frame, descend
			S_NBR: begin
				if (visited_q[nbr_rdata]) begin
					state_d = S_WALK;
				end else if (out_free) begin
					res_load             = 1'b1;
					res.vertex           = 3'(pend_q);
					res.status           = gdfs_pkg::ST_VISIT;
					res.last             = 1'b0;
					pend_d               = nbr_rdata;
					visited_d[nbr_rdata] = 1'b1;
					stk_we               = 1'b1;
					stk_waddr            = depth_m1[VI_W-1:0];
					stk_wdata            = {top_v_q, top_pos_q};
					top_v_d              = nbr_rdata;
					top_pos_d            = '0;
					depth_d              = depth_q + CNT_W'(1);
					state_d              = S_WALK;
				end
			end
			S_POP: begin
				top_v_d   = stk_rdata[FR_W-1:CNT_W];
				top_pos_d = stk_rdata[CNT_W-1:0];
				state_d   = S_WALK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			depth_q   <= '0;
			visited_q <= '0;
			cnt_q     <= '{default: '0};
		end else begin
			state_q   <= state_d;
			depth_q   <= depth_d;
			visited_q <= visited_d;
			cnt_q     <= cnt_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		s_q       <= s_d;
		d_q       <= d_d;
		scan_q    <= scan_d;
		top_v_q   <= top_v_d;
		top_pos_q <= top_pos_d;
		pend_q    <= pend_d;
	end

	// adjacency lists, row per source vertex
	gdfs_ram #(
		.DATA_W (VI_W),
		.ADDR_W (NA_W)
	) u_nbr_ram (
		.clk   (clk),
		.we    (nbr_we),
		.waddr (nbr_waddr),
		.wdata (nbr_wdata),
		.re    (nbr_re),
		.raddr (nbr_raddr),
		.rdata (nbr_rdata)
	);

	// walk stack frames below the cached top
	gdfs_ram #(
		.DATA_W (FR_W),
		.ADDR_W (VI_W)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	gdfs_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (res_load),
		.res           (res),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= CNT_W'(NV))
		else $error("walk stack deeper than vertex count");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> out_free)
		else $error("result loaded into a busy output register");

	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == gdfs_pkg::REQ_WALK && src_ok)
		|=> $onehot(visited_q) && depth_q == CNT_W'(1))
		else $error("traversal did not start from a single marked vertex");

	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && state_d == S_IDLE) |-> (res_load && res.last))
		else $error("traversal ended without a final visit report");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD_RD) |-> cnt_s <= CNT_W'(NV))
		else $error("neighbor list longer than vertex count");
`endif

endmodule
